// ----- rtl/core/deq_pkg.sv -----
package deq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_TOP = 3'd0,
    OP_PUSH_BOT = 3'd1,
    OP_POP_TOP  = 3'd2,
    OP_POP_BOT  = 3'd3,
    OP_REVERSE  = 3'd4,
    OP_SPLIT    = 3'd5,
    OP_NOP6     = 3'd6,
    OP_NOP7     = 3'd7
  } deq_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2,
    ST_RSVD      = 2'd3
  } deq_status_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] push_value;
    logic signed [31:0] split_threshold;
  } deq_in_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [8:0]         element_count;
    logic [1:0]         status;
  } deq_out_t;

endpackage

// ----- rtl/core/deq_ram.sv -----
module deq_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/core/deq_front.sv -----
module deq_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  deq_pkg::deq_in_t in_data_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output deq_pkg::deq_in_t q_data_o
);
  import deq_pkg::*;

  // two-entry command queue between intake and execution
  deq_in_t    buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- rtl/core/deq_back.sv -----
module deq_back #(
  parameter int Depth     = 256,
  parameter int DataWidth = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  deq_pkg::deq_in_t  cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output deq_pkg::deq_out_t out_data_o
);
  import deq_pkg::*;

  localparam int Aw = $clog2(Depth);
  localparam int Cw = $clog2(Depth + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_POPRD = 7'b0000010,
    S_CPRD  = 7'b0000100,
    S_CPWR  = 7'b0001000,
    S_SPRD  = 7'b0010000,
    S_SPWR  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e         state_q, state_d;
  logic [Aw-1:0]  top_q, top_d;
  logic [Cw-1:0]  cnt_q, cnt_d;
  logic           rev_q, rev_d;
  logic [Cw-1:0]  i_q, i_d, n_q, n_d;
  logic           pass_q, pass_d;
  logic [31:0]    thr_q, thr_d;
  logic [DataWidth-1:0] pv_q, pv_d;
  logic [1:0]     st_q, st_d;
  logic           ov_q, ov_d;
  deq_out_t       od_q, od_d;

  logic                 e_we, s_we;
  logic [Aw-1:0]        e_wa, e_ra, s_wa, s_ra;
  logic [DataWidth-1:0] e_wd, e_rd, s_rd;

  deq_ram #(.Width(DataWidth), .Depth(Depth)) u_elem (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd),
    .raddr_i(e_ra), .rdata_o(e_rd));
  deq_ram #(.Width(DataWidth), .Depth(Depth)) u_scr (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(e_rd),
    .raddr_i(s_ra), .rdata_o(s_rd));

  // physical slot of logical position (0 = top)
  function automatic logic [Aw-1:0] slot(logic [Aw-1:0] t, logic r, logic [Cw-1:0] p);
    logic [Aw:0] s;
    logic [Aw:0] pp;
    pp = {1'b0, p[Aw-1:0]};
    if (r) begin
      s = {1'b0, t} + (Aw+1)'(Depth) - pp;
    end else begin
      s = {1'b0, t} + pp;
    end
    if (s >= (Aw+1)'(Depth)) s = s - (Aw+1)'(Depth);
    return s[Aw-1:0];
  endfunction

  logic [Cw-1:0] cnt_m1;
  logic [DataWidth-1:0] pushw;
  logic ge, take;
  assign cnt_m1 = cnt_q - Cw'(1);
  assign pushw = DataWidth'(cmd_i.push_value);
  // element sign-extended against the full threshold
  assign ge = $signed(s_rd) >= $signed(thr_q);
  assign take = pass_q ? !ge : ge;
  assign cmd_ready_o = (state_q == S_IDLE) && !(ov_q && !out_ready_i);

  always_comb begin
    state_d = state_q; top_d = top_q; cnt_d = cnt_q; rev_d = rev_q;
    i_d = i_q; n_d = n_q; pass_d = pass_q; thr_d = thr_q;
    pv_d = pv_q; st_d = st_q; ov_d = ov_q; od_d = od_q;
    e_we = 1'b0; e_wa = '0; e_wd = pushw; e_ra = top_q;
    s_we = 1'b0; s_wa = i_q[Aw-1:0]; s_ra = i_q[Aw-1:0];
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          pv_d = '0; st_d = ST_OK; state_d = S_DONE;
          unique case (deq_op_e'(cmd_i.opcode))
            OP_PUSH_TOP, OP_PUSH_BOT: begin
              if (cnt_q >= Cw'(Depth)) st_d = ST_PUSH_FULL;
              else begin
                e_we = 1'b1;
                cnt_d = cnt_q + Cw'(1);
                if (cmd_i.opcode == OP_PUSH_TOP) begin
                  top_d = slot(top_q, ~rev_q, Cw'(1));
                  e_wa = top_d;
                end else e_wa = slot(top_q, rev_q, cnt_q);
              end
            end
            OP_POP_TOP, OP_POP_BOT: begin
              if (cnt_q == '0) st_d = ST_POP_EMPTY;
              else begin
                state_d = S_POPRD;
                cnt_d = cnt_m1;
                if (cmd_i.opcode == OP_POP_TOP) begin
                  e_ra = top_q;
                  top_d = slot(top_q, rev_q, Cw'(1));
                end else e_ra = slot(top_q, rev_q, cnt_m1);
              end
            end
            OP_REVERSE: begin
              if (cnt_q > Cw'(1)) begin
                top_d = slot(top_q, rev_q, cnt_m1);
                rev_d = ~rev_q;
              end
            end
            OP_SPLIT: begin
              if (cnt_q > Cw'(1)) begin
                thr_d = cmd_i.split_threshold;
                i_d = '0;
                state_d = S_CPRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_POPRD: state_d = S_DONE;
      S_CPRD: begin
        // read element i, written to scratch next cycle
        e_ra = slot(top_q, rev_q, i_q);
        state_d = S_CPWR;
      end
      S_CPWR: begin
        s_we = 1'b1;
        if (i_q == cnt_m1) begin
          i_d = '0; n_d = '0; pass_d = 1'b0; state_d = S_SPRD;
        end else begin
          i_d = i_q + Cw'(1); state_d = S_CPRD;
        end
      end
      S_SPRD: state_d = S_SPWR;
      S_SPWR: begin
        e_wd = s_rd;
        e_wa = slot(top_q, rev_q, n_q);
        if (take) begin
          e_we = 1'b1;
          n_d = n_q + Cw'(1);
        end
        state_d = S_SPRD;
        if (i_q == cnt_m1) begin
          i_d = '0;
          if (pass_q) state_d = S_DONE;
          pass_d = 1'b1;
        end else i_d = i_q + Cw'(1);
      end
      S_DONE: begin
        if (!ov_d) begin
          ov_d = 1'b1;
          od_d.pop_value = 32'($signed(st_q == ST_OK ? pv_q : '0));
          od_d.element_count = 9'(cnt_q);
          od_d.status = st_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_POPRD) pv_d = e_rd;
  end

  always_ff @(posedge clk_i) begin
    thr_q <= thr_d; pv_q <= pv_d; st_q <= st_d; od_q <= od_d;
    i_q <= i_d; n_q <= n_d; pass_q <= pass_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; top_q <= '0; cnt_q <= '0; rev_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; top_q <= top_d; cnt_q <= cnt_d; rev_q <= rev_d; ov_q <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o = od_q;
endmodule

// ----- rtl/core/double_ended_queue_engine.sv -----
// channel | valid      | ready      | payload
// in      | in_valid_i | in_ready_o | in_data_i  (deq_in_t)
// out     | out_valid_o| out_ready_i| out_data_o (deq_out_t)
// push, reverse, no-op and pop on empty go from the queue head straight to the result state,
// pops that remove an element first pass through a ram read state
// split copies each element to scratch (a read state, then a write state),
// then makes two filtering passes, each a read state and a write state per element
// reset clears pointers and count; ram contents stay undefined
// a two-entry command queue keeps intake open while the back end works
module double_ended_queue_engine #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  deq_pkg::deq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output deq_pkg::deq_out_t out_data_o
);
  import deq_pkg::*;

  logic    q_valid, q_ready;
  deq_in_t q_data;

  deq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data));

  deq_back #(.Depth(DEPTH), .DataWidth(DATA_WIDTH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_data),
    .out_valid_o, .out_ready_i, .out_data_o);
endmodule

// ----- dv/double_ended_queue_engine_tb.sv -----
module double_ended_queue_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int QDEPTH = 256;

  // reference deque state, kept in logical order (index 0 = top)
  class deque_scoreboard;
    logic signed [31:0] contents[$];
    deq_out_t expected_q[$];
    int mismatches;
    int unmatched;

    function void note_input(deq_in_t item);
      deq_out_t r;
      logic signed [31:0] hi_part[$];
      logic signed [31:0] lo_part[$];
      r = '0;
      r.status = ST_OK;
      case (deq_op_e'(item.opcode))
        OP_PUSH_TOP, OP_PUSH_BOT: begin
          if (contents.size() >= QDEPTH) begin
            r.status = ST_PUSH_FULL;
          end else if (item.opcode == OP_PUSH_TOP) begin
            contents.push_front(item.push_value);
          end else begin
            contents.push_back(item.push_value);
          end
        end
        OP_POP_TOP, OP_POP_BOT: begin
          if (contents.size() == 0) begin
            r.status = ST_POP_EMPTY;
          end else if (item.opcode == OP_POP_TOP) begin
            r.pop_value = contents.pop_front();
          end else begin
            r.pop_value = contents.pop_back();
          end
        end
        OP_REVERSE: begin
          contents.reverse();
        end
        OP_SPLIT: begin
          foreach (contents[i]) begin
            if (contents[i] >= item.split_threshold) hi_part.push_back(contents[i]);
            else lo_part.push_back(contents[i]);
          end
          contents = {hi_part, lo_part};
        end
        default: ;
      endcase
      r.element_count = 9'(contents.size());
      expected_q.push_back(r);
    endfunction

    function void check_result(deq_out_t got);
      deq_out_t exp_r;
      if (expected_q.size() == 0) begin
        unmatched++;
        $display("unexpected result beat: %h", got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.pop_value !== exp_r.pop_value || got.element_count !== exp_r.element_count ||
          got.status !== exp_r.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp val=%0d cnt=%0d st=%0d, got val=%0d cnt=%0d st=%0d",
                   exp_r.pop_value, exp_r.element_count, exp_r.status,
                   got.pop_value, got.element_count, got.status);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  deq_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  deq_out_t out_data_o;

  deque_scoreboard sb;
  bit long_stall;
  bit stim_done;

  double_ended_queue_engine DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // accepted beats on both sides
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_input(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // receiver stall pattern; long hold-off when requested
  initial begin
    int mode;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_stall) begin
        out_ready_i <= 1'b0;
        repeat (600) @(negedge clk_i);
        long_stall = 1'b0;
      end
      mode = ($urandom_range(0, 199) / 50);
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2: out_ready_i <= ($urandom_range(0, 1) != 0);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_item(deq_op_e op, logic signed [31:0] val, logic signed [31:0] thr);
    in_valid_i <= 1'b1;
    in_data_i <= '{opcode: op, push_value: val, split_threshold: thr};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 20)) - 32'd10);
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic random_item(int push_bias);
    int r;
    deq_op_e op;
    r = $urandom_range(0, 99);
    if (r < push_bias) op = ($urandom_range(0, 1) != 0) ? OP_PUSH_TOP : OP_PUSH_BOT;
    else if (r < 85) op = ($urandom_range(0, 1) != 0) ? OP_POP_TOP : OP_POP_BOT;
    else if (r < 91) op = OP_REVERSE;
    else if (r < 97) op = OP_SPLIT;
    else op = ($urandom_range(0, 1) != 0) ? OP_NOP6 : OP_NOP7;
    send_item(op, rand_word(), rand_word());
  endtask

  initial begin
    int sent;
    int burst;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    long_stall = 1'b0;
    stim_done = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty pops, degenerate reverse/split, extremes, no-ops
    send_item(OP_POP_TOP, 0, 0);
    send_item(OP_POP_BOT, 0, 0);
    send_item(OP_REVERSE, 0, 0);
    send_item(OP_SPLIT, 0, 0);
    send_item(OP_PUSH_TOP, 32'sh7fffffff, 0);
    send_item(OP_SPLIT, 0, 32'sh80000000);
    send_item(OP_REVERSE, 0, 0);
    send_item(OP_PUSH_BOT, 32'sh80000000, 0);
    send_item(OP_PUSH_TOP, -1, 0);
    send_item(OP_PUSH_BOT, 0, 0);
    send_item(OP_SPLIT, 0, 0);
    send_item(OP_REVERSE, 0, 0);
    send_item(OP_SPLIT, 0, 32'sh7fffffff);
    send_item(OP_SPLIT, 0, 32'sh80000000);
    send_item(OP_NOP6, -1, -1);
    send_item(OP_NOP7, 0, 0);
    send_item(OP_POP_TOP, 0, 0);
    send_item(OP_POP_BOT, 0, 0);
    send_item(OP_POP_TOP, 0, 0);
    send_item(OP_POP_BOT, 0, 0);
    send_item(OP_POP_BOT, 0, 0);

    // fill to full with the receiver held off, then overflow pushes
    long_stall = 1'b1;
    repeat (QDEPTH + 3) send_item(($urandom_range(0, 1) != 0) ? OP_PUSH_TOP : OP_PUSH_BOT,
                                  rand_word(), 0);
    send_item(OP_SPLIT, 0, 0);
    send_item(OP_REVERSE, 0, 0);
    repeat (20) random_item(50);

    // random bursts; bias toward pops when the queue is large
    sent = 0;
    while (sent < 600) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        random_item((sb.contents.size() > 200) ? 20 : (sb.contents.size() < 8 ? 70 : 45));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.unmatched == 0 && sb.expected_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
